/* sv/ias_pkg.sv */
// package for the indexed array store: payload structs, operation and status codes
// and the sequencer state type; no dependencies
package ias_pkg;

  localparam int unsigned IdxW  = 10;
  localparam int unsigned DataW = 32;
  localparam int unsigned CntW  = 11;

  typedef enum logic [1:0] {
    MODE_GET    = 2'd0,
    MODE_SET    = 2'd1,
    MODE_PUSH   = 2'd2,
    MODE_REMOVE = 2'd3
  } ias_mode_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } ias_status_e;

  typedef enum logic {
    S_IDLE  = 1'b0,
    S_SHIFT = 1'b1
  } ias_state_e;

  typedef struct packed {
    ias_mode_e          mode;
    logic [IdxW-1:0]    index;
    logic signed [DataW-1:0] value;
  } ias_in_t;

  typedef struct packed {
    logic signed [DataW-1:0] read_value;
    logic [1:0]         status;
    logic [CntW-1:0]    count;
    logic [CntW-1:0]    room;
  } ias_out_t;

endpackage

/* sv/ias_ram.sv */
// entry storage: one write port and one read port, read data registered
// depends on ias_pkg for the word width
module ias_ram #(
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [AW-1:0]               waddr_i,
  input  logic [ias_pkg::DataW-1:0]   wdata_i,
  input  logic                        re_i,
  input  logic [AW-1:0]               raddr_i,
  output logic [ias_pkg::DataW-1:0]   rdata_o
);

  logic [ias_pkg::DataW-1:0] mem [DEPTH];
  logic [ias_pkg::DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/ias_ctrl.sv */
// operation sequencer: decodes requests, keeps size and capacity, drives the
// entry memory and runs the shift-down pass of a remove; depends on ias_pkg
module ias_ctrl #(
  parameter int unsigned MAX_ENTRIES = 1024,
  localparam int unsigned AW = $clog2(MAX_ENTRIES)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  ias_pkg::ias_in_t           req_i,
  output logic                       mem_we_o,
  output logic [AW-1:0]              mem_waddr_o,
  output logic [ias_pkg::DataW-1:0]  mem_wdata_o,
  output logic                       mem_re_o,
  output logic [AW-1:0]              mem_raddr_o,
  input  logic [ias_pkg::DataW-1:0]  mem_rdata_i,
  output logic                       rsp_valid_o,
  output logic                       rsp_from_mem_o,
  output ias_pkg::ias_out_t          rsp_o
);

  localparam int unsigned CW   = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned CPW  = CW + 1;
  localparam int unsigned CMPW = (CW > ias_pkg::IdxW + 1) ? CW : ias_pkg::IdxW + 1;

  ias_pkg::ias_state_e state_q, state_d;
  logic [CW-1:0]       used_q, used_d;
  logic [CPW-1:0]      cap_q, cap_d;
  logic [CW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]       end_q, end_d;
  logic [AW-1:0]       wr_addr_q, wr_addr_d;
  logic                pend_q, pend_d;
  logic                rsp_valid_q, rsp_valid_d;
  logic                from_mem_q, from_mem_d;
  ias_pkg::ias_out_t   rsp_q, rsp_d;

  logic accept;
  logic idx_ok;
  logic need_shift;
  logic is_full;
  logic issue;
  logic shift_done;

  assign busy       = (state_q != ias_pkg::S_IDLE);
  assign accept     = start && !busy;
  assign idx_ok     = CMPW'(req_i.index) < CMPW'(used_q);
  assign need_shift = (CMPW'(req_i.index) + CMPW'(1)) < CMPW'(used_q);
  assign is_full    = (used_q == CW'(MAX_ENTRIES));
  assign issue      = (rd_ptr_q <= end_q);
  assign shift_done = !issue && !pend_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ias_pkg::S_IDLE: begin
        if (accept && req_i.mode == ias_pkg::MODE_REMOVE && idx_ok && need_shift) begin
          state_d = ias_pkg::S_SHIFT;
        end
      end
      ias_pkg::S_SHIFT: begin
        if (shift_done) begin
          state_d = ias_pkg::S_IDLE;
        end
      end
      default: state_d = ias_pkg::S_IDLE;
    endcase
  end

  // memory port controls
  always_comb begin
    mem_we_o    = 1'b0;
    mem_waddr_o = '0;
    mem_wdata_o = req_i.value;
    mem_re_o    = 1'b0;
    mem_raddr_o = '0;
    unique case (state_q)
      ias_pkg::S_IDLE: begin
        if (accept) begin
          unique case (req_i.mode)
            ias_pkg::MODE_GET: begin
              mem_re_o    = idx_ok;
              mem_raddr_o = AW'(req_i.index);
            end
            ias_pkg::MODE_SET: begin
              mem_we_o    = idx_ok;
              mem_waddr_o = AW'(req_i.index);
            end
            ias_pkg::MODE_PUSH: begin
              mem_we_o    = !is_full;
              mem_waddr_o = AW'(used_q);
            end
            default: ;
          endcase
        end
      end
      ias_pkg::S_SHIFT: begin
        mem_re_o    = issue;
        mem_raddr_o = AW'(rd_ptr_q);
        mem_we_o    = pend_q;
        mem_waddr_o = wr_addr_q;
        mem_wdata_o = mem_rdata_i;
      end
      default: ;
    endcase
  end

  // size, capacity, shift pointers and result
  always_comb begin
    used_d      = used_q;
    cap_d       = cap_q;
    rd_ptr_d    = rd_ptr_q;
    end_d       = end_q;
    wr_addr_d   = wr_addr_q;
    pend_d      = 1'b0;
    rsp_valid_d = 1'b0;
    from_mem_d  = 1'b0;
    rsp_d       = rsp_q;
    if (state_q == ias_pkg::S_IDLE) begin
      if (accept) begin
        rsp_d.read_value = '0;
        rsp_d.status     = ias_pkg::ST_OK;
        rsp_valid_d      = 1'b1;
        if (req_i.mode == ias_pkg::MODE_PUSH) begin
          if (is_full) begin
            rsp_d.status = ias_pkg::ST_FULL;
          end else begin
            if (CPW'(used_q) == cap_q) begin
              cap_d = cap_q << 1;
            end
            used_d = used_q + CW'(1);
          end
        end else if (!idx_ok) begin
          rsp_d.status = ias_pkg::ST_RANGE;
          if (req_i.mode == ias_pkg::MODE_GET) begin
            rsp_d.read_value = '1;
          end
        end else if (req_i.mode == ias_pkg::MODE_GET) begin
          from_mem_d = 1'b1;
        end else if (req_i.mode == ias_pkg::MODE_REMOVE) begin
          used_d      = used_q - CW'(1);
          rd_ptr_d    = CW'(req_i.index) + CW'(1);
          end_d       = used_q - CW'(1);
          rsp_valid_d = !need_shift;
        end
        rsp_d.count = ias_pkg::CntW'(used_d);
        rsp_d.room  = ias_pkg::CntW'(cap_d);
      end
    end else begin
      if (issue) begin
        rd_ptr_d  = rd_ptr_q + CW'(1);
        wr_addr_d = AW'(rd_ptr_q - CW'(1));
      end
      pend_d      = issue;
      rsp_valid_d = shift_done;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ias_pkg::S_IDLE;
      used_q      <= '0;
      cap_q       <= CPW'(1);
      pend_q      <= 1'b0;
      rsp_valid_q <= 1'b0;
      from_mem_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      cap_q       <= cap_d;
      pend_q      <= pend_d;
      rsp_valid_q <= rsp_valid_d;
      from_mem_q  <= from_mem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_ptr_q  <= rd_ptr_d;
    end_q     <= end_d;
    wr_addr_q <= wr_addr_d;
    rsp_q     <= rsp_d;
  end

  assign rsp_valid_o    = rsp_valid_q;
  assign rsp_from_mem_o = from_mem_q;
  assign rsp_o          = rsp_q;

endmodule

/* sv/indexed_array_store_core.sv */
// top level of the indexed array store: sequencer plus entry memory, result merge
// depends on ias_pkg, ias_ctrl and ias_ram
//
// channel   ports                    transfer when
// request   start, busy, req_i       rising edge with start high and busy low
// result    done_o, result_o         rising edge ending the cycle done_o is high
//
// get, set, push: result in the cycle after the transfer, a new request each idle cycle
// remove with later entries to move: busy while they move, one entry moved per cycle
// through the single read and write port of the entry memory; result in the first
// cycle with busy low
// remove of the last entry or out of range: result in the cycle after the transfer
// reset clears size to zero and capacity to one; entries need no clearing
// results cannot be held off by the receiver
module indexed_array_store_core #(
  parameter int unsigned MAX_ENTRIES = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  ias_pkg::ias_in_t  req_i,
  output logic              done_o,
  output ias_pkg::ias_out_t result_o
);

  localparam int unsigned AW = $clog2(MAX_ENTRIES);

  logic                      mem_we;
  logic [AW-1:0]             mem_waddr;
  logic [ias_pkg::DataW-1:0] mem_wdata;
  logic                      mem_re;
  logic [AW-1:0]             mem_raddr;
  logic [ias_pkg::DataW-1:0] mem_rdata;
  logic                      rsp_from_mem;
  ias_pkg::ias_out_t         rsp;

  ias_ctrl #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .req_i         (req_i),
    .mem_we_o      (mem_we),
    .mem_waddr_o   (mem_waddr),
    .mem_wdata_o   (mem_wdata),
    .mem_re_o      (mem_re),
    .mem_raddr_o   (mem_raddr),
    .mem_rdata_i   (mem_rdata),
    .rsp_valid_o   (done_o),
    .rsp_from_mem_o(rsp_from_mem),
    .rsp_o         (rsp)
  );

  ias_ram #(
    .DEPTH(MAX_ENTRIES)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  always_comb begin
    result_o = rsp;
    if (rsp_from_mem) begin
      result_o.read_value = mem_rdata;
    end
  end

  a_quick_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && req_i.mode != ias_pkg::MODE_REMOVE |=> done_o)
    else $error("no result after a single-access request");

  a_no_port_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we && mem_re |-> mem_waddr != mem_raddr)
    else $error("shift reads and writes the same entry");

  a_shift_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o)
    else $error("remove finished without a result");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.status == ias_pkg::ST_FULL
      |-> result_o.count == ias_pkg::CntW'(MAX_ENTRIES))
    else $error("full reported below maximum size");

endmodule
